### rtl/bpm_pkg.sv
// Shared constants and types of the bijective pattern matcher.
`timescale 1ns / 1ps
package bpm_pkg;

    localparam int MAX_PATTERN_LEN = 16;
    localparam int LANE_W          = $clog2(MAX_PATTERN_LEN);
    localparam int POS_W           = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2
    } t_cfg_idx;

    // One classified byte of a word passed from the front to the back.
    typedef struct packed {
        logic [7:0] pattern_byte;
        logic [7:0] word_byte;
        logic       in_range;
        logic       word_end;
        logic       length_ok;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

### rtl/bpm_word_if.sv
// Handshake interfaces for input words and result words.
`timescale 1ns / 1ps
interface bpm_word_if;
    logic       valid;
    logic       ready;
    logic [7:0] word_byte;
    logic       word_end;

    modport source (output valid, output word_byte, output word_end, input ready);
    modport sink   (input valid, input word_byte, input word_end, output ready);
endinterface

interface bpm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

### rtl/bpm_front.sv
// Front end: configuration registers, word position and classification of each input byte.
`timescale 1ns / 1ps
module bpm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_valid,
    input  logic [7:0]                     i_word_byte,
    input  logic                           i_word_end,
    output logic                           o_ready,
    input  bpm_pkg::t_queue_status         i_queue_status,
    output logic                           o_push,
    output bpm_pkg::t_cmd                  o_cmd
);
    import bpm_pkg::*;

    logic [CFG_DATA_W-1:0]     r_pat_low;
    logic [CFG_DATA_W-1:0]     r_pat_high;
    logic [POS_W-1:0]          r_pat_len;
    logic [POS_W-1:0]          r_pos;
    logic [POS_W-1:0]          n_pos;
    logic [POS_W-1:0]          eff_len;
    logic [POS_W-1:0]          pos_inc;
    logic [2*CFG_DATA_W-1:0]   pat_all;
    logic                      accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= POS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_wdata;
                CFG_PATTERN_HIGH: r_pat_high <= i_cfg_wdata;
                CFG_PATTERN_LEN:  r_pat_len  <= i_cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign eff_len = (r_pat_len > POS_W'(MAX_PATTERN_LEN)) ? POS_W'(MAX_PATTERN_LEN)
                                                            : r_pat_len;
    assign pat_all = {r_pat_high, r_pat_low};
    assign pos_inc = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    assign accept  = i_valid && !i_queue_status.full;

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = i_word_end ? '0 : pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_ready = !i_queue_status.full;
    assign o_push  = accept;

    always_comb begin
        o_cmd.pattern_byte = pat_all[{r_pos[LANE_W-1:0], 3'b000} +: 8];
        o_cmd.word_byte    = i_word_byte;
        o_cmd.in_range     = r_pos < eff_len;
        o_cmd.word_end     = i_word_end;
        o_cmd.length_ok    = pos_inc == eff_len;
    end

endmodule

### rtl/bpm_queue.sv
// Short first-in first-out queue between the front and the back.
`timescale 1ns / 1ps
module bpm_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  bpm_pkg::t_cmd          i_cmd,
    input  logic                   i_pop,
    output bpm_pkg::t_cmd          o_cmd,
    output bpm_pkg::t_queue_status o_status
);
    import bpm_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_status.full  = r_count == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

### rtl/bpm_back.sv
// Back end: history lanes of the current word, conflict check and result register.
`timescale 1ns / 1ps
module bpm_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bpm_pkg::t_cmd          i_cmd,
    input  bpm_pkg::t_queue_status i_queue_status,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic                   o_matched,
    input  logic                   i_ready
);
    import bpm_pkg::*;

    logic [7:0]        r_lane_pb [MAX_PATTERN_LEN];
    logic [7:0]        r_lane_wb [MAX_PATTERN_LEN];
    logic [POS_W-1:0]  r_fill;
    logic              r_mis;
    logic              r_out_valid;
    logic              r_out_matched;
    logic              conflict;
    logic              mis_now;
    logic              out_free;

    // With no mismatch so far every stored pair agrees with both maps, so a new
    // pair breaks a map exactly when it conflicts with some earlier lane.
    always_comb begin
        conflict = 1'b0;
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            if (POS_W'(j) < r_fill) begin
                if ((r_lane_pb[j] == i_cmd.pattern_byte) != (r_lane_wb[j] == i_cmd.word_byte)) begin
                    conflict = 1'b1;
                end
            end
        end
    end

    assign mis_now  = r_mis || !i_cmd.in_range || conflict;
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = !i_queue_status.empty && (!i_cmd.word_end || out_free);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.in_range) begin
            r_lane_pb[r_fill[LANE_W-1:0]] <= i_cmd.pattern_byte;
            r_lane_wb[r_fill[LANE_W-1:0]] <= i_cmd.word_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_mis  <= 1'b0;
        end else if (o_pop) begin
            if (i_cmd.word_end) begin
                r_fill <= '0;
                r_mis  <= 1'b0;
            end else begin
                r_mis <= mis_now;
                if (i_cmd.in_range) begin
                    r_fill <= r_fill + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cmd.word_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.word_end) begin
            r_out_matched <= !mis_now && i_cmd.length_ok;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_out_matched;

endmodule

### rtl/bijective_pattern_matcher_unit.sv
// Top level of the bijective pattern matcher.
//
//  channel   direction  payload                 handshake
//  i_word    in         word_byte, word_end     valid/ready
//  o_result  out        matched                 valid/ready
//  cfg       in         i_cfg_index, wdata      i_cfg_we, no stall
//
// One byte is taken per cycle unless the queue is full; the back end checks it
// against up to 16 history lanes, so the sustained rate is one byte per cycle
// while the output is not stalled. With the queue empty and the output free,
// a word's closing byte passes through the queue and then the result register.
// A four-entry queue between front and back absorbs output stalls; input
// ready drops only when that queue is full. Reset is synchronous and clears
// the position, the queue and the result register; no clearing pass is needed.
`timescale 1ns / 1ps
module bijective_pattern_matcher_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    bpm_word_if.sink                       i_word,
    bpm_result_if.source                   o_result
);
    import bpm_pkg::*;

    t_cmd          push_cmd;
    t_cmd          head_cmd;
    t_queue_status queue_status;
    logic          push;
    logic          pop;

    bpm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_word.valid),
        .i_word_byte    (i_word.word_byte),
        .i_word_end     (i_word.word_end),
        .o_ready        (i_word.ready),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    bpm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (queue_status)
    );

    bpm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .o_valid        (o_result.valid),
        .o_matched      (o_result.matched),
        .i_ready        (o_result.ready)
    );

endmodule

### rtl/bpm_checker.sv
// Port-level checker for the bijective pattern matcher and its bind statement.
`timescale 1ns / 1ps
module bpm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_end,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_matched
);
    import bpm_pkg::*;

    localparam int PEND_W = QUEUE_CNT_W + 1;

    logic [PEND_W-1:0] r_pending;
    logic              end_in;
    logic              res_out;

    assign end_in  = i_in_valid && i_in_ready && i_in_end;
    assign res_out = i_out_valid && i_out_ready;

    // Words that closed a candidate but whose result has not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (end_in && !res_out) begin
            r_pending <= r_pending + PEND_W'(1);
        end else if (res_out && !end_in) begin
            r_pending <= r_pending - PEND_W'(1);
        end
    end

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != '0)
        else $error("result shown without a closed word");

    a_pending_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(QUEUE_DEPTH + 1))
        else $error("more closed words in flight than the design can hold");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_matched))
        else $error("stalled result changed");

endmodule

bind bijective_pattern_matcher_unit bpm_checker u_bpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_word.valid),
    .i_in_ready    (i_word.ready),
    .i_in_end      (i_word.word_end),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_matched (o_result.matched)
);
